FILE: hw/rtl/string_literal_escape_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the string literal escape decoder checker
// ----------------------------------------------------------------------------
`ifndef STRING_LITERAL_ESCAPE_DECODER_ASSERT_SVH
`define STRING_LITERAL_ESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SLED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SLED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sled_pkg.sv
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types, character codes and helpers for the escape decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sled_pkg;

  localparam int MAX_LEN    = 4096;
  localparam int KEEP_LIMIT = (MAX_LEN < 8191) ? MAX_LEN : 8191;
  localparam int KEPT_W     = 13;

  // Character codes
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_T = 8'h74;
  localparam logic [7:0] CH_LC_R = 8'h72;
  localparam logic [7:0] CH_LC_E = 8'h65;

  localparam logic [KEPT_W-1:0] KEEP_MAX = KEPT_W'(KEEP_LIMIT);

  // Decoder state carried from one body byte to the next
  typedef struct packed {
    logic              esc_pend;
    logic              ecr_pend;
    logic [7:0]        prev_byte;
    logic              first;
    logic [15:0]       line;
    logic [15:0]       col;
    logic [KEPT_W-1:0] kept;
    logic              ovf;
  } sled_state_t;

  // One decoded output byte with its own count and truncation status
  typedef struct packed {
    logic [7:0]        data;
    logic              has;
    logic              trunc;
    logic [KEPT_W-1:0] kept;
  } sled_slot_t;

  // Everything one body byte produces: one or two slots plus shared fields
  typedef struct packed {
    sled_slot_t  slot0;
    sled_slot_t  slot1;
    logic        two;
    logic        bad;
    logic        last;
    logic [15:0] line;
    logic [15:0] col;
  } sled_result_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sled_decode.sv
// ----------------------------------------------------------------------------
// sled_decode
// Single-pass escape decode of one body byte: next state and result pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sled_decode (
  input  wire sled_pkg::sled_state_t  st,
  input  wire                         crlf_on,
  input  wire [7:0]                   in_byte,
  input  wire                         is_last,
  output sled_pkg::sled_state_t       st_next,
  output sled_pkg::sled_result_t      res
);
  import sled_pkg::*;

  sled_state_t       base;
  logic [1:0]        n_emit;
  logic [7:0]        e0;
  logic [7:0]        e1;
  logic              bad;
  logic              do_raw;
  logic              ok0;
  logic              ok1;
  logic [KEPT_W-1:0] cnt1;
  logic [KEPT_W-1:0] cnt2;
  logic              ovf1;
  logic              ovf2;

  // Byte classification and state update
  always_comb begin
    base = st;
    if (st.first) begin
      base.line     = '0;
      base.col      = '0;
      base.kept     = '0;
      base.ovf      = 1'b0;
      base.esc_pend = 1'b0;
      base.ecr_pend = 1'b0;
    end
    st_next           = base;
    st_next.first     = is_last;
    st_next.prev_byte = in_byte;
    n_emit = 2'd0;
    e0     = '0;
    e1     = '0;
    bad    = 1'b0;
    do_raw = 1'b0;

    if (base.ecr_pend) begin
      // backslash CR seen: LF completes the continuation, else raw byte
      st_next.ecr_pend = 1'b0;
      if (in_byte == CH_LF) begin
        st_next.line = sat_inc16(base.line);
        st_next.col  = '0;
      end else begin
        do_raw = 1'b1;
      end
    end else if (base.esc_pend) begin
      st_next.esc_pend = 1'b0;
      st_next.col      = sat_inc16(base.col);
      unique case (in_byte)
        CH_CR: st_next.ecr_pend = 1'b1;
        CH_LF: begin
          st_next.line = sat_inc16(base.line);
          st_next.col  = '0;
        end
        CH_BSL: begin
          n_emit = 2'd1;
          e0     = CH_BSL;
        end
        CH_DQ: begin
          n_emit = 2'd1;
          e0     = CH_DQ;
        end
        CH_LC_N: begin
          if (crlf_on) begin
            n_emit = 2'd2;
            e0     = CH_CR;
            e1     = CH_LF;
          end else begin
            n_emit = 2'd1;
            e0     = CH_LF;
          end
        end
        CH_LC_T: begin
          n_emit = 2'd1;
          e0     = CH_TAB;
        end
        CH_LC_R: begin
          n_emit = 2'd1;
          e0     = CH_CR;
        end
        CH_LC_E: begin
          n_emit = 2'd1;
          e0     = CH_ESC;
        end
        default: begin
          n_emit = 2'd1;
          e0     = in_byte;
          bad    = 1'b1;
        end
      endcase
    end else begin
      do_raw = 1'b1;
    end

    // Raw (unescaped) byte
    if (do_raw) begin
      if (in_byte == CH_LF) begin
        st_next.line = sat_inc16(base.line);
        st_next.col  = '0;
      end else begin
        st_next.col  = sat_inc16(base.col);
      end
      if (in_byte == CH_BSL) begin
        st_next.esc_pend = 1'b1;
      end else if (crlf_on && !st.first && base.prev_byte != CH_CR &&
                   in_byte == CH_LF) begin
        n_emit = 2'd2;
        e0     = CH_CR;
        e1     = CH_LF;
      end else begin
        n_emit = 2'd1;
        e0     = in_byte;
      end
    end

    // Closing quote column, plus one for a dangling backslash
    if (is_last) begin
      if (st_next.esc_pend) begin
        st_next.col = sat_inc16(st_next.col);
      end
      st_next.col      = sat_inc16(st_next.col);
      st_next.esc_pend = 1'b0;
      st_next.ecr_pend = 1'b0;
    end

    // Keep-limit accounting for up to two emitted bytes
    ok0  = (n_emit != 2'd0) && (base.kept < KEEP_MAX);
    cnt1 = base.kept + KEPT_W'(ok0);
    ovf1 = base.ovf | ((n_emit != 2'd0) && !ok0);
    ok1  = (n_emit == 2'd2) && (cnt1 < KEEP_MAX);
    cnt2 = cnt1 + KEPT_W'(ok1);
    ovf2 = ovf1 | ((n_emit == 2'd2) && !ok1);

    st_next.kept = cnt2;
    st_next.ovf  = ovf2;
  end

  // Result pair
  always_comb begin
    res.slot0.data  = ok0 ? e0 : 8'h00;
    res.slot0.has   = ok0;
    res.slot0.trunc = ovf1;
    res.slot0.kept  = cnt1;
    res.slot1.data  = ok1 ? e1 : 8'h00;
    res.slot1.has   = ok1;
    res.slot1.trunc = ovf2;
    res.slot1.kept  = cnt2;
    res.two         = (n_emit == 2'd2);
    res.bad         = bad;
    res.last        = is_last;
    res.line        = st_next.line;
    res.col         = st_next.col;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sled_outbuf.sv
// ----------------------------------------------------------------------------
// sled_outbuf
// Result register holding one or two decoded bytes, drained one per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sled_outbuf (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          load,
  input  wire sled_pkg::sled_result_t  res_in,
  output logic                         free,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [7:0]                   out_byte,
  output logic                         has_data,
  output logic                         bad_escape,
  output logic                         truncated,
  output logic [15:0]                  line_advance,
  output logic [15:0]                  column,
  output logic [sled_pkg::KEPT_W-1:0]  kept_count,
  output logic                         end_mark
);
  import sled_pkg::*;

  sled_result_t res;
  logic         rvalid;
  logic         sel;
  logic         fire;
  logic         pop;
  sled_slot_t   cur;

  assign fire = rvalid && !out_stall;
  assign pop  = fire && (!res.two || sel);
  assign free = !rvalid || pop;

  // Control: valid and slot select
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
      sel    <= 1'b0;
    end else if (load) begin
      rvalid <= 1'b1;
      sel    <= 1'b0;
    end else if (pop) begin
      rvalid <= 1'b0;
      sel    <= 1'b0;
    end else if (fire) begin
      sel    <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

  assign cur          = sel ? res.slot1 : res.slot0;
  assign out_valid    = rvalid;
  assign out_byte     = cur.data;
  assign has_data     = cur.has;
  assign truncated    = cur.trunc;
  assign kept_count   = cur.kept;
  assign bad_escape   = res.bad;
  assign line_advance = res.line;
  assign column       = res.col;
  assign end_mark     = res.last && (!res.two || sel);

endmodule

`default_nettype wire

FILE: hw/rtl/string_literal_escape_decoder.sv
// ----------------------------------------------------------------------------
// string_literal_escape_decoder
// Decodes backslash escapes in string literal body bytes, with line/column
// tracking, optional CR LF expansion and a kept-byte limit.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  in      | in  | in_valid / in_stall    | in_byte, is_last
//  out     | out | out_valid / out_stall  | out_byte, has_data, bad_escape,
//          |     |                        | truncated, line_advance, column,
//          |     |                        | kept_count, end_mark
//  cfg     | in  | cfg_valid / cfg_ready  | crlf_mode
//
//  An input request passes through the input register, then the result
//  register. One byte per cycle sustained while out_stall is low; a byte that
//  expands to CR LF holds the result register for two output requests, so the
//  input stalls meanwhile. Synchronous reset returns to the start of a literal
//  with crlf_mode 0. out_stall back-pressures straight to in_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module string_literal_escape_decoder (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [7:0]                    in_byte,
  input  wire                          is_last,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [7:0]                   out_byte,
  output logic                         has_data,
  output logic                         bad_escape,
  output logic                         truncated,
  output logic [15:0]                  line_advance,
  output logic [15:0]                  column,
  output logic [sled_pkg::KEPT_W-1:0]  kept_count,
  output logic                         end_mark,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire                          crlf_mode
);
  import sled_pkg::*;

  logic         crlf_on;
  logic         svalid;
  logic [7:0]   sbyte;
  logic         slast;
  logic         rfree;
  logic         advance;
  sled_state_t  st;
  sled_state_t  st_next;
  sled_result_t res_d;

  assign cfg_ready = 1'b1;
  assign advance   = svalid && rfree;
  assign in_stall  = svalid && !rfree;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      crlf_on <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      crlf_on <= crlf_mode;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      svalid <= 1'b0;
    end else if (!in_stall) begin
      svalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      sbyte <= in_byte;
      slast <= is_last;
    end
  end

  // Decoder state, updated as each byte moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.esc_pend  <= 1'b0;
      st.ecr_pend  <= 1'b0;
      st.prev_byte <= '0;
      st.first     <= 1'b1;
      st.line      <= '0;
      st.col       <= '0;
      st.kept      <= '0;
      st.ovf       <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  sled_decode u_decode (
    .st      (st),
    .crlf_on (crlf_on),
    .in_byte (sbyte),
    .is_last (slast),
    .st_next (st_next),
    .res     (res_d)
  );

  sled_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .res_in       (res_d),
    .free         (rfree),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .has_data     (has_data),
    .bad_escape   (bad_escape),
    .truncated    (truncated),
    .line_advance (line_advance),
    .column       (column),
    .kept_count   (kept_count),
    .end_mark     (end_mark)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/sled_checker.sv
// ----------------------------------------------------------------------------
// sled_checker
// Port-level checks for the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "string_literal_escape_decoder_assert.svh"

module sled_checker (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          out_valid,
  input  wire                          out_stall,
  input  wire [7:0]                    out_byte,
  input  wire                          has_data,
  input  wire                          truncated,
  input  wire [sled_pkg::KEPT_W-1:0]   kept_count
);
  import sled_pkg::*;

  // Empty results carry a zero byte
  `SLED_ASSERT_NOW(a_empty_zero, out_valid && !has_data, out_byte == 8'h00, "empty result with nonzero byte")

  // A kept byte always counts
  `SLED_ASSERT_NOW(a_kept_nonzero, out_valid && has_data, kept_count != '0, "kept byte with zero count")

  // Count never passes the limit
  `SLED_ASSERT_NOW(a_kept_limit, out_valid, kept_count <= KEEP_MAX, "kept count above limit")

  // After truncation nothing more is kept
  `SLED_ASSERT_NOW(a_trunc_drop, out_valid && truncated, !has_data, "byte kept after truncation")

  // A stalled result holds
  `SLED_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte), "stalled result changed")

endmodule

bind string_literal_escape_decoder sled_checker u_sled_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .has_data   (has_data),
  .truncated  (truncated),
  .kept_count (kept_count)
);

`default_nettype wire

FILE: test/string_literal_escape_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_tb
// Self-checking bench for the string literal escape decoder. A queue of body
// bytes feeds a bursty sender and a receiver stalls on its own pattern. Each
// accepted request runs through a local decoder model, and every output
// request is checked in order against the decoded bytes that the model
// expects. Covers escapes, line joins and CR LF expansion in both modes.
// ----------------------------------------------------------------------------

module string_literal_escape_decoder_tb;

  import sled_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  // One body byte waiting to be sent
  typedef struct {
    logic [7:0] b;
    logic       fin;
  } body_item_t;

  // One decoded result as the block should present it
  typedef struct packed {
    logic [7:0]        ch;
    logic              has;
    logic              bad;
    logic              trunc;
    logic [15:0]       line;
    logic [15:0]       col;
    logic [KEPT_W-1:0] kept;
    logic              endm;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [7:0]        in_byte   = 8'h00;
  logic              is_last   = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_byte;
  logic              has_data;
  logic              bad_escape;
  logic              truncated;
  logic [15:0]       line_advance;
  logic [15:0]       column;
  logic [KEPT_W-1:0] kept_count;
  logic              end_mark;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              crlf_mode = 1'b0;

  string_literal_escape_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .has_data     (has_data),
    .bad_escape   (bad_escape),
    .truncated    (truncated),
    .line_advance (line_advance),
    .column       (column),
    .kept_count   (kept_count),
    .end_mark     (end_mark),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .crlf_mode    (crlf_mode)
  );

  always #5 clk = ~clk;

  body_item_t body_q[$];
  decoded_t   decoded_q[$];
  int         queued_cnt   = 0;
  int         accepted_cnt = 0;
  int         mismatch_cnt = 0;
  int         cycle_cnt    = 0;

  // Decoder model state, reset values
  logic              crlf_on    = 1'b0;
  logic              esc_pend   = 1'b0;
  logic              ecr_pend   = 1'b0;
  logic [7:0]        prev_raw   = 8'h00;
  logic              start_flag = 1'b1;
  logic [15:0]       line_cnt   = '0;
  logic [15:0]       col_cnt    = '0;
  logic [KEPT_W-1:0] kept_cnt   = '0;
  logic              trunc_flag = 1'b0;

  // Bytes decoded by the current request
  int                n_slots;
  logic [7:0]        slot_ch[2];
  logic              slot_has[2];
  logic              slot_trunc[2];
  logic [KEPT_W-1:0] slot_kept[2];

  function automatic logic [15:0] bump16(logic [15:0] v);
    return v + 16'(v != 16'hFFFF);
  endfunction

  // Keep a decoded byte, or drop it once the limit is reached
  function automatic void keep_byte(logic [7:0] b);
    if (n_slots < 2) begin
      if (kept_cnt < KEEP_LIMIT) begin
        kept_cnt = kept_cnt + 1'b1;
        slot_ch[n_slots]  = b;
        slot_has[n_slots] = 1'b1;
      end else begin
        trunc_flag = 1'b1;
        slot_ch[n_slots]  = 8'h00;
        slot_has[n_slots] = 1'b0;
      end
      slot_kept[n_slots]  = kept_cnt;
      slot_trunc[n_slots] = trunc_flag;
      n_slots++;
    end
  endfunction

  // Unescaped byte: counts, backslash arms an escape, LF may expand
  function automatic void raw_step(logic [7:0] b, bit lead);
    col_cnt = bump16(col_cnt);
    if (b == CH_LF) begin
      line_cnt = bump16(line_cnt);
      col_cnt  = '0;
    end
    if (b == CH_BSL) begin
      esc_pend = 1'b1;
    end else begin
      if (crlf_on && !lead && prev_raw != CH_CR && b == CH_LF) keep_byte(CH_CR);
      keep_byte(b);
    end
    prev_raw = b;
  endfunction

  // Decode one accepted request and queue its expected results
  function automatic void decode_request(logic [7:0] b, logic fin);
    bit       lead;
    bit       bad;
    decoded_t r;
    lead = start_flag;
    bad  = 1'b0;
    if (lead) begin
      line_cnt   = '0;
      col_cnt    = '0;
      kept_cnt   = '0;
      trunc_flag = 1'b0;
      esc_pend   = 1'b0;
      ecr_pend   = 1'b0;
    end
    start_flag = 1'b0;
    n_slots    = 0;

    if (ecr_pend) begin
      // backslash CR: an LF completes the line join, anything else is raw
      ecr_pend = 1'b0;
      if (b == CH_LF) begin
        line_cnt = bump16(line_cnt);
        col_cnt  = '0;
        prev_raw = b;
      end else begin
        raw_step(b, lead);
      end
    end else if (esc_pend) begin
      esc_pend = 1'b0;
      col_cnt  = bump16(col_cnt);
      case (b)
        CH_CR:   ecr_pend = 1'b1;
        CH_LF: begin
          line_cnt = bump16(line_cnt);
          col_cnt  = '0;
        end
        CH_BSL:  keep_byte(CH_BSL);
        CH_DQ:   keep_byte(CH_DQ);
        CH_LC_N: begin
          if (crlf_on) keep_byte(CH_CR);
          keep_byte(CH_LF);
        end
        CH_LC_T: keep_byte(CH_TAB);
        CH_LC_R: keep_byte(CH_CR);
        CH_LC_E: keep_byte(CH_ESC);
        default: begin
          keep_byte(b);
          bad = 1'b1;
        end
      endcase
      prev_raw = b;
    end else begin
      raw_step(b, lead);
    end

    // closing quote, plus the terminator a trailing backslash would escape
    if (fin) begin
      if (esc_pend) col_cnt = bump16(col_cnt);
      col_cnt    = bump16(col_cnt);
      esc_pend   = 1'b0;
      ecr_pend   = 1'b0;
      start_flag = 1'b1;
    end

    if (n_slots == 0) begin
      slot_ch[0]    = 8'h00;
      slot_has[0]   = 1'b0;
      slot_kept[0]  = kept_cnt;
      slot_trunc[0] = trunc_flag;
      n_slots       = 1;
    end

    for (int k = 0; k < n_slots; k++) begin
      r.ch    = slot_ch[k];
      r.has   = slot_has[k];
      r.bad   = bad;
      r.trunc = slot_trunc[k];
      r.line  = line_cnt;
      r.col   = col_cnt;
      r.kept  = slot_kept[k];
      r.endm  = fin && (k == n_slots - 1);
      decoded_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_body(logic [7:0] b, logic fin);
    body_item_t it;
    it.b   = b;
    it.fin = fin;
    body_q.push_back(it);
    queued_cnt++;
  endfunction

  function automatic void push_literal(logic [7:0] body[$]);
    foreach (body[i]) push_body(body[i], i == body.size() - 1);
  endfunction

  // Well-formed literal with random content, some noise and odd endings
  function automatic int add_random_literal();
    logic [7:0] esc_set[10];
    logic [7:0] body[$];
    int         len;
    int         pick;
    int         sel;
    esc_set = '{CH_BSL, CH_DQ, CH_LC_N, CH_LC_T, CH_LC_R, CH_LC_E,
                CH_LF, CH_CR, 8'h00, 8'hFF};
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
    while (body.size() < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        body.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 55) begin
        sel = $urandom_range(0, 11);
        body.push_back(CH_BSL);
        body.push_back(sel < 10 ? esc_set[sel] : 8'($urandom));
      end else if (pick < 63) begin
        body.push_back(CH_LF);
      end else if (pick < 68) begin
        body.push_back(CH_CR);
      end else if (pick < 73) begin
        body.push_back(CH_CR);
        body.push_back(CH_LF);
      end else if (pick < 78) begin
        body.push_back(CH_BSL);
        body.push_back(CH_CR);
        body.push_back(CH_LF);
      end else begin
        body.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 11) == 0) body.push_back(CH_BSL);
    push_literal(body);
    return body.size();
  endfunction

  // Write crlf_mode while nothing is in flight
  task automatic set_mode(logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    crlf_mode <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    crlf_on = v;
  endtask

  // Hold off until every queued byte is in and every result is out
  task automatic settle_idle();
    while (accepted_cnt != queued_cnt || decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left   = 0;
  body_item_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_request(in_byte, is_last);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && body_q.size() != 0) begin
          nxt = body_q.pop_front();
          in_valid <= 1'b1;
          in_byte  <= nxt.b;
          is_last  <= nxt.fin;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 15) == 0) ? 200 : $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: none, light, heavy or periodic, in random spans
  // ---------------------------------------------------------------------------
  int stall_style = 0;
  int stall_span  = 0;
  int stall_tick  = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_span  = $urandom_range(16, 300);
      end
      stall_span--;
      stall_tick++;
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_tick % 3 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  decoded_t seen;
  decoded_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = '{out_byte, has_data, bad_escape, truncated, line_advance, column,
               kept_count, end_mark};
      if (decoded_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("ERROR %0t: result with none expected, byte=%h", $time, out_byte);
        mismatch_cnt++;
      end else begin
        want = decoded_q.pop_front();
        if (seen.ch !== want.ch || seen.has !== want.has || seen.bad !== want.bad ||
            seen.trunc !== want.trunc || seen.line !== want.line ||
            seen.col !== want.col || seen.kept !== want.kept ||
            seen.endm !== want.endm) begin
          if (mismatch_cnt < 10) begin
            $display("ERROR %0t: exp byte=%h has=%b bad=%b trunc=%b line=%0d col=%0d kept=%0d end=%b",
                     $time, want.ch, want.has, want.bad, want.trunc, want.line, want.col,
                     want.kept, want.endm);
            $display("ERROR %0t: got byte=%h has=%b bad=%b trunc=%b line=%0d col=%0d kept=%0d end=%b",
                     $time, seen.ch, seen.has, seen.bad, seen.trunc, seen.line, seen.col,
                     seen.kept, seen.endm);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] body[$];
    int         added;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // LF mode: raw NUL, escapes n, t, e, backslash and quote, escaped NUL, trailing backslash
    set_mode(1'b0);
    body = '{8'h00, CH_BSL, CH_LC_N, CH_BSL, CH_LC_T, CH_BSL, CH_LC_E,
             CH_BSL, CH_BSL, CH_BSL, CH_DQ, CH_BSL, 8'h00, CH_BSL};
    push_literal(body);
    settle_idle();

    // CR LF mode: leading LF, expanded LF, CR LF, \n, a line join,
    // escaped lone CR, escaped CR as the final byte
    set_mode(1'b1);
    body = '{CH_LF, CH_LF, CH_CR, CH_LF, CH_BSL, CH_LC_N, CH_BSL, CH_LF,
             CH_BSL, CH_CR, 8'h78, CH_BSL, CH_CR};
    push_literal(body);
    settle_idle();

    // Random literals, alternating modes
    for (int p = 0; p < 4; p++) begin
      set_mode(p % 2 == 0);
      added = 0;
      while (added < 170) added += add_random_literal();
      settle_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
